>>> hw/rtl/assert_macros.svh
// Assertion helpers included by the controller core.
// Each macro checks on the rising edge and is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/dcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg
// Types, sizes and codes shared by the dwell-click controller files.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int COORD_BITS    = 12;
  localparam int TICK_BITS     = 8;
  localparam int MOVE_BITS     = COORD_BITS + 2;
  localparam int MIN_MOVE_BITS = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Button action codes
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_CLICK   = 3'd1;
  localparam logic [2:0] ACT_PRESS   = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_RIGHT   = 3'd4;
  localparam logic [2:0] ACT_DOUBLE  = 3'd5;

  // Stroke kinds
  localparam logic [1:0] STROKE_NORMAL   = 2'd0;
  localparam logic [1:0] STROKE_SUPPRESS = 2'd1;
  localparam logic [1:0] STROKE_RIGHT    = 2'd2;
  localparam logic [1:0] STROKE_DOUBLE   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_MOVE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DWELL      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SMART_DRAG = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STROKES_ON = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOUND_ON   = 3'd6;

  typedef struct packed {
    logic [COORD_BITS-1:0] pointer_x;
    logic [COORD_BITS-1:0] pointer_y;
    logic [1:0]            stroke_kind;
  } dcc_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic       sound;
    logic       button_held;
  } dcc_out_t;

  typedef struct packed {
    logic                     enabled;
    logic [MIN_MOVE_BITS-1:0] move_thresh;
    logic [TICK_BITS-1:0]     dwell_ticks;
    logic [TICK_BITS-1:0]     drag_ticks;
    logic                     smart_drag;
    logic                     strokes_on;
    logic                     sound_on;
  } dcc_cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS:0] last_x;
    logic signed [COORD_BITS:0] last_y;
    logic                       moving;
    logic [TICK_BITS:0]         still_ticks;
    logic                       held;
    logic                       first_move;
  } dcc_state_t;

endpackage

>>> hw/rtl/dcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_step
// Combinational tick update: motion test, still counter and click decision.
// ----------------------------------------------------------------------------
module dcc_step import dcc_pkg::*; (
  input  dcc_cfg_t   cfg,
  input  dcc_state_t state_cur,
  input  dcc_in_t    item,
  output dcc_state_t state_nxt,
  output dcc_out_t   result
);

  logic signed [MOVE_BITS-1:0] dx;
  logic signed [MOVE_BITS-1:0] dy;
  logic [MOVE_BITS-1:0]        adx;
  logic [MOVE_BITS-1:0]        ady;
  logic [MOVE_BITS-1:0]        thr;
  logic                        moved;
  logic [TICK_BITS:0]          ceiling;
  logic [TICK_BITS:0]          count;
  logic                        hit;
  logic                        normal;

  // Signed distance from the last moved-to position on each axis
  assign dx = $signed({2'b00, item.pointer_x})
            - $signed({state_cur.last_x[COORD_BITS], state_cur.last_x});
  assign dy = $signed({2'b00, item.pointer_y})
            - $signed({state_cur.last_y[COORD_BITS], state_cur.last_y});
  assign adx = dx[MOVE_BITS-1] ? MOVE_BITS'(-dx) : MOVE_BITS'(dx);
  assign ady = dy[MOVE_BITS-1] ? MOVE_BITS'(-dy) : MOVE_BITS'(dy);

  // Threshold is one pixel while moving, the configured minimum while still
  assign thr = state_cur.moving ? MOVE_BITS'(1)
                                : {{(MOVE_BITS-MIN_MOVE_BITS){1'b0}}, cfg.move_thresh};
  assign moved = (adx >= thr) || (ady >= thr);

  // Advance the still counter up to the ceiling and test for the dwell point
  assign ceiling = {1'b0, cfg.dwell_ticks} + {1'b0, cfg.drag_ticks};
  assign count   = (state_cur.still_ticks < ceiling) ? state_cur.still_ticks + 1'b1
                                                     : state_cur.still_ticks;
  assign hit     = (count == {1'b0, cfg.dwell_ticks});
  assign normal  = hit && (state_cur.held || !cfg.strokes_on ||
                           item.stroke_kind == STROKE_NORMAL);

  always_comb begin
    state_nxt          = state_cur;
    result.action      = ACT_NONE;
    result.sound       = 1'b0;
    if (cfg.enabled) begin
      state_nxt.moving = moved;
      if (moved) begin
        state_nxt.last_x = $signed({1'b0, item.pointer_x});
        state_nxt.last_y = $signed({1'b0, item.pointer_y});
        // First move after reset parks the counter at its ceiling
        if (state_cur.first_move) begin
          state_nxt.first_move  = 1'b0;
          state_nxt.still_ticks = ceiling;
        end else begin
          state_nxt.still_ticks = '0;
        end
      end else begin
        state_nxt.still_ticks = count;
        if (normal) begin
          if (cfg.smart_drag) begin
            if (!state_cur.held) begin
              result.action         = ACT_PRESS;
              result.sound          = cfg.sound_on;
              state_nxt.held        = 1'b1;
              state_nxt.still_ticks = '0;
            end else begin
              result.action         = ACT_RELEASE;
              state_nxt.held        = 1'b0;
              state_nxt.still_ticks = ceiling;
            end
          end else begin
            result.action = ACT_CLICK;
            result.sound  = cfg.sound_on;
          end
        end else if (hit) begin
          case (item.stroke_kind)
            STROKE_RIGHT:    result.action = ACT_RIGHT;
            STROKE_DOUBLE:   result.action = ACT_DOUBLE;
            STROKE_SUPPRESS: result.action = ACT_NONE;
            default:         result.action = ACT_NONE;
          endcase
        end
      end
    end
    result.button_held = state_nxt.held;
  end

endmodule

>>> hw/rtl/dwell_click_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwell_click_controller_core
// Dwell-click controller: one button action for each pointer tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one tick: pointer
//   column, row and a stroke kind. Result channel (out_valid / out_stall /
//   out_data) returns exactly one action per tick, in order.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   one register per transfer; cfg_ready is always high. Write it only while
//   no tick is in flight.
//   Path: a tick enters the input register on its transfer, passes the step
//   logic into the result register and is then shown on out_valid.
//   Throughput: one tick per cycle while out_stall is low; the single-pass
//   step logic between the input and result registers sets that figure.
//   Stall: while out_stall holds, the result register keeps its transfer and
//   the input register can still fill; in_stall rises once both are full.
//   Reset: pointer history goes to minus one, counters clear, the button is
//   released, config takes its defaults; tick and result data are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwell_click_controller_core import dcc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  dcc_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output dcc_out_t                 out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  dcc_cfg_t   cfg_r;
  dcc_state_t state_r;
  dcc_state_t state_nxt;
  dcc_in_t    item_r;
  logic       item_valid_r;
  dcc_out_t   res_r;
  logic       res_valid_r;
  dcc_out_t   step_res;
  logic       res_free;
  logic       advance;

  assign cfg_ready = 1'b1;
  assign res_free  = !res_valid_r || !out_stall;
  assign advance   = item_valid_r && res_free;
  assign in_stall  = item_valid_r && !res_free;
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled      <= 1'b0;
      cfg_r.move_thresh  <= MIN_MOVE_BITS'(5);
      cfg_r.dwell_ticks  <= TICK_BITS'(5);
      cfg_r.drag_ticks   <= TICK_BITS'(3);
      cfg_r.smart_drag   <= 1'b0;
      cfg_r.strokes_on   <= 1'b0;
      cfg_r.sound_on     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLED:    cfg_r.enabled      <= cfg_data[0];
        CFG_MIN_MOVE:   cfg_r.move_thresh  <= cfg_data[MIN_MOVE_BITS-1:0];
        CFG_DWELL:      cfg_r.dwell_ticks  <= cfg_data[TICK_BITS-1:0];
        CFG_DRAG:       cfg_r.drag_ticks   <= cfg_data[TICK_BITS-1:0];
        CFG_SMART_DRAG: cfg_r.smart_drag   <= cfg_data[0];
        CFG_STROKES_ON: cfg_r.strokes_on   <= cfg_data[0];
        CFG_SOUND_ON:   cfg_r.sound_on     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the incoming tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  // Per-tick update logic
  dcc_step u_step (
    .cfg       (cfg_r),
    .state_cur (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Commit controller state as the tick moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_x      <= '1;
      state_r.last_y      <= '1;
      state_r.moving      <= 1'b0;
      state_r.still_ticks <= '0;
      state_r.held        <= 1'b0;
      state_r.first_move  <= 1'b1;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Hold the result until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  // Sound only accompanies a left click or a press
  `ASSERT_IMPLIES(a_sound_kind, clk, rst_n, out_valid && out_data.sound,
    out_data.action == ACT_CLICK || out_data.action == ACT_PRESS)
  // A press leaves the button held, a release leaves it free
  `ASSERT_IMPLIES(a_press_held, clk, rst_n, out_valid && out_data.action == ACT_PRESS,
    out_data.button_held)
  `ASSERT_IMPLIES(a_release_free, clk, rst_n,
    out_valid && out_data.action == ACT_RELEASE, !out_data.button_held)
  // Reported button state tracks the committed held state
  `ASSERT_NEXT(a_held_match, clk, rst_n, advance, out_data.button_held == state_r.held)
  // Backpressure only with a full input register
  `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, item_valid_r && res_valid_r)

endmodule
